### design/sblru_pkg.sv
// ----------------------------------------------------------------------------
// sblru_pkg
// Shared constants for the size-bounded LRU store: table size, field widths,
// command codes, status codes and config register indices.
// ----------------------------------------------------------------------------
package sblru_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int BYTES_W  = 40;
    localparam int SIZE_W   = 32;
    localparam int KEY_W    = 32;
    localparam int CLASS_W  = 4;
    localparam int REFS_W   = 16;
    localparam int EVICT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_STORE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNLIMITED = 1'd1;

    // Saturating bump; a static count of zero stays zero.
    function automatic logic [REFS_W-1:0] bump(input logic [REFS_W-1:0] r);
        logic [REFS_W-1:0] res;
        res = r;
        if (r != '0 && r != '1)
            res = r + 1'b1;
        return res;
    endfunction

endpackage

### design/size_budget_lru_store.sv
// ----------------------------------------------------------------------------
// size_budget_lru_store
// A table of cached resources kept in LRU order, with a byte budget that
// evicts unpinned entries from the least recent end before a store.
// ----------------------------------------------------------------------------
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// in       | in_valid, in_ready, command .. value_refs      | sink
// out      | out_valid, out_ready, status .. value_freed    | source
// cfg      | cfg_we, cfg_index, cfg_data                    | sink
//
// Find, remove and release go from the lookup state to the output beat. A
// store may run the eviction check and the eviction pass before its insert;
// both walk the ranks one per cycle through one shared byte adder/compare.
// The block takes one beat at a time; in_ready is low from acceptance until
// the result beat leaves. Reset clears valid bits, used bytes and the FSM.
// ----------------------------------------------------------------------------
module size_budget_lru_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sblru_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sblru_pkg::BYTES_W-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sblru_pkg::CMD_W-1:0]          command,
    input  logic [sblru_pkg::KEY_W-1:0]          key,
    input  logic [sblru_pkg::CLASS_W-1:0]        key_class,
    input  logic                                 indexed,
    input  logic [sblru_pkg::SIZE_W-1:0]         item_size,
    input  logic [sblru_pkg::REFS_W-1:0]         value_refs,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sblru_pkg::STATUS_W-1:0]       status,
    output logic [sblru_pkg::REFS_W-1:0]         entry_count_out,
    output logic [sblru_pkg::EVICT_W-1:0]        evicted,
    output logic [sblru_pkg::BYTES_W-1:0]        total_bytes,
    output logic                                 value_freed
);

    localparam int N  = sblru_pkg::ENTRIES;
    localparam int IW = sblru_pkg::IDX_W;
    localparam int CW = sblru_pkg::CNT_W;
    localparam int BW = sblru_pkg::BYTES_W;
    localparam int EVICT_W_L = sblru_pkg::EVICT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_CHECK, S_EVICT, S_INSERT, S_OUT
    } state_t;

    state_t                          state_reg;
    logic [N-1:0]                    valid_reg;
    logic [sblru_pkg::KEY_W-1:0]     key_mem   [N];
    logic [sblru_pkg::CLASS_W-1:0]   class_mem [N];
    logic                            idx_mem   [N];
    logic [sblru_pkg::SIZE_W-1:0]    bytes_mem [N];
    logic [sblru_pkg::REFS_W-1:0]    refs_mem  [N];
    logic [IW-1:0]                   age_mem   [N];
    logic [BW-1:0]                   used_reg;
    logic [BW-1:0]                   budget_reg;
    logic                            unlimited_reg;

    logic [sblru_pkg::CMD_W-1:0]     cmd_reg;
    logic [sblru_pkg::KEY_W-1:0]     key_reg;
    logic [sblru_pkg::CLASS_W-1:0]   class_reg;
    logic                            idx_reg;
    logic [sblru_pkg::SIZE_W-1:0]    size_reg;
    logic [sblru_pkg::REFS_W-1:0]    vr_reg;
    logic [BW-1:0]                   tofree_reg;
    logic [BW-1:0]                   sum_reg;
    logic [CW-1:0]                   rank_reg;   // rank + 1, counts down
    logic [EVICT_W_L-1:0]            ev_reg;

    logic [sblru_pkg::STATUS_W-1:0]  status_reg;
    logic [sblru_pkg::REFS_W-1:0]    cnt_reg;
    logic                            freed_reg;

    // Match and rank decode, all per-entry and parallel.
    logic [N-1:0] hit_vec;
    logic [N-1:0] rank_vec;
    logic         hit_any;
    logic [IW-1:0] hit_slot;
    logic [IW-1:0] hit_age;
    logic         rank_any;
    logic [IW-1:0] rank_slot;
    logic         free_any;
    logic [IW-1:0] free_slot;
    logic [CW-1:0] n_valid;
    logic [IW-1:0] cur_rank;

    assign cur_rank = rank_reg[IW-1:0] - 1'b1;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit_vec[i]  = valid_reg[i] && key_mem[i] == key_reg
                          && class_mem[i] == class_reg
                          && (!idx_reg || idx_mem[i]);
            rank_vec[i] = valid_reg[i] && age_mem[i] == cur_rank;
        end
        hit_any = 1'b0;
        hit_slot = '0;
        hit_age = '0;
        rank_any = 1'b0;
        rank_slot = '0;
        free_any = 1'b0;
        free_slot = '0;
        n_valid = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_slot = IW'(i);
            end
            if (rank_vec[i])
            begin
                rank_any = 1'b1;
                rank_slot = IW'(i);
            end
        end
        for (int i = 0; i < N; i++)
        begin
            n_valid = n_valid + CW'(valid_reg[i]);
            // Strict compare keeps the first of equal ages, as the search does.
            if (hit_vec[i] && (!hit_any || age_mem[i] < hit_age))
            begin
                hit_any = 1'b1;
                hit_slot = IW'(i);
                hit_age = age_mem[i];
            end
        end
    end

    // The shared byte unit: one add and one compare per cycle.
    logic [BW-1:0] sum_add;
    logic          cand;
    assign cand    = rank_any && refs_mem[rank_slot] == 16'd1;
    assign sum_add = sum_reg + BW'(bytes_mem[rank_slot]);

    logic [BW-1:0] need;
    assign need = used_reg + BW'(size_reg);

    assign in_ready        = state_reg == S_IDLE;
    assign out_valid       = state_reg == S_OUT;
    assign status          = status_reg;
    assign entry_count_out = cnt_reg;
    assign evicted         = ev_reg;
    assign total_bytes     = used_reg;
    assign value_freed     = freed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= '0;
            unlimited_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sblru_pkg::REG_BUDGET:    budget_reg <= cfg_data;
                sblru_pkg::REG_UNLIMITED: unlimited_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            class_reg <= key_class;
            idx_reg   <= indexed;
            size_reg  <= item_size;
            vr_reg    <= value_refs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            used_reg  <= '0;
            status_reg <= sblru_pkg::ST_MISS;
            cnt_reg   <= '0;
            ev_reg    <= '0;
            freed_reg <= 1'b0;
            sum_reg   <= '0;
            tofree_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_LOOKUP;
                end
                S_LOOKUP:
                begin
                    ev_reg     <= '0;
                    sum_reg    <= '0;
                    tofree_reg <= need - budget_reg;
                    rank_reg   <= n_valid;
                    if (cmd_reg == sblru_pkg::CMD_STORE && !(idx_reg && hit_any))
                    begin
                        // Status and count of a new entry are set on insert.
                        status_reg <= sblru_pkg::ST_MISS;
                        cnt_reg    <= '0;
                        freed_reg  <= 1'b0;
                        if (!unlimited_reg && need > budget_reg)
                            state_reg <= S_CHECK;
                        else
                            state_reg <= S_INSERT;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        if (!hit_any)
                        begin
                            status_reg <= sblru_pkg::ST_MISS;
                            cnt_reg    <= '0;
                            freed_reg  <= 1'b0;
                        end
                        else
                        begin
                            unique case (cmd_reg)
                                sblru_pkg::CMD_STORE, sblru_pkg::CMD_FIND:
                                begin
                                    for (int j = 0; j < N; j++)
                                        if (valid_reg[j] && age_mem[j] < hit_age)
                                            age_mem[j] <= age_mem[j] + 1'b1;
                                    age_mem[hit_slot] <= '0;
                                    refs_mem[hit_slot] <=
                                        sblru_pkg::bump(refs_mem[hit_slot]);
                                    cnt_reg <= sblru_pkg::bump(refs_mem[hit_slot]);
                                    freed_reg  <= 1'b0;
                                    status_reg <= sblru_pkg::ST_FOUND;
                                end
                                sblru_pkg::CMD_REMOVE:
                                begin
                                    for (int j = 0; j < N; j++)
                                        if (valid_reg[j] && age_mem[j] > hit_age)
                                            age_mem[j] <= age_mem[j] - 1'b1;
                                    valid_reg[hit_slot] <= 1'b0;
                                    used_reg <= used_reg - BW'(bytes_mem[hit_slot]);
                                    if (refs_mem[hit_slot] != '0)
                                    begin
                                        refs_mem[hit_slot] <= refs_mem[hit_slot] - 1'b1;
                                        cnt_reg <= refs_mem[hit_slot] - 1'b1;
                                        freed_reg <= refs_mem[hit_slot] == 16'd1;
                                    end
                                    else
                                    begin
                                        cnt_reg   <= '0;
                                        freed_reg <= 1'b0;
                                    end
                                    status_reg <= sblru_pkg::ST_REMOVED;
                                end
                                sblru_pkg::CMD_RELEASE:
                                begin
                                    if (refs_mem[hit_slot] > 16'd1)
                                    begin
                                        refs_mem[hit_slot] <= refs_mem[hit_slot] - 1'b1;
                                        cnt_reg <= refs_mem[hit_slot] - 1'b1;
                                    end
                                    else
                                        cnt_reg <= refs_mem[hit_slot];
                                    freed_reg  <= 1'b0;
                                    status_reg <= sblru_pkg::ST_RELEASED;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_CHECK:
                begin
                    // Walk ranks from the least recent end, summing unpinned sizes.
                    if (rank_reg == '0)
                        state_reg <= S_INSERT;
                    else if (cand && sum_add >= tofree_reg)
                    begin
                        sum_reg  <= '0;
                        rank_reg <= n_valid;
                        state_reg <= S_EVICT;
                    end
                    else
                    begin
                        if (cand)
                            sum_reg <= sum_add;
                        rank_reg <= rank_reg - 1'b1;
                    end
                end
                S_EVICT:
                begin
                    // Ranks above the victim drop by one, so the walk stays
                    // on the next rank down after an eviction.
                    rank_reg <= rank_reg - 1'b1;
                    if (cand)
                    begin
                        for (int j = 0; j < N; j++)
                            if (valid_reg[j] && age_mem[j] > cur_rank)
                                age_mem[j] <= age_mem[j] - 1'b1;
                        valid_reg[rank_slot] <= 1'b0;
                        used_reg <= used_reg - BW'(bytes_mem[rank_slot]);
                        sum_reg  <= sum_add;
                        ev_reg   <= ev_reg + 1'b1;
                    end
                    if (rank_reg == CW'(1) || (cand && sum_add >= tofree_reg))
                        state_reg <= S_INSERT;
                end
                S_INSERT:
                begin
                    state_reg <= S_OUT;
                    if (!free_any)
                        status_reg <= sblru_pkg::ST_FULL;
                    else
                    begin
                        for (int j = 0; j < N; j++)
                            if (valid_reg[j])
                                age_mem[j] <= age_mem[j] + 1'b1;
                        valid_reg[free_slot] <= 1'b1;
                        key_mem[free_slot]   <= key_reg;
                        class_mem[free_slot] <= class_reg;
                        idx_mem[free_slot]   <= idx_reg;
                        bytes_mem[free_slot] <= size_reg;
                        refs_mem[free_slot]  <= sblru_pkg::bump(vr_reg);
                        age_mem[free_slot]   <= '0;
                        used_reg   <= used_reg + BW'(size_reg);
                        cnt_reg    <= sblru_pkg::bump(vr_reg);
                        status_reg <= sblru_pkg::ST_STORED;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-bounded LRU store. It runs a directed
// sequence and then random store/find/remove/release traffic over a small key
// pool, with several budget settings. Every result beat is checked against an
// in-bench model of the table, and both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES   = sblru_pkg::ENTRIES;
    localparam int CMD_W     = sblru_pkg::CMD_W;
    localparam int KEY_W     = sblru_pkg::KEY_W;
    localparam int CLASS_W   = sblru_pkg::CLASS_W;
    localparam int SIZE_W    = sblru_pkg::SIZE_W;
    localparam int REFS_W    = sblru_pkg::REFS_W;
    localparam int STATUS_W  = sblru_pkg::STATUS_W;
    localparam int EVICT_W   = sblru_pkg::EVICT_W;
    localparam int BYTES_W   = sblru_pkg::BYTES_W;
    localparam int CFG_IDX_W = sblru_pkg::CFG_IDX_W;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [CLASS_W-1:0] cls;
        logic               idx;
        logic [SIZE_W-1:0]  size;
        logic [REFS_W-1:0]  refs;
    } op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [REFS_W-1:0]   count;
        logic [EVICT_W-1:0]  evicted;
        logic [BYTES_W-1:0]  total;
        logic                freed;
    } reply_t;

    class lru_scoreboard;
        bit               vld [ENTRIES];
        bit [KEY_W-1:0]   skey [ENTRIES];
        bit [CLASS_W-1:0] scls [ENTRIES];
        bit               sidx [ENTRIES];
        bit [SIZE_W-1:0]  ssize [ENTRIES];
        bit [REFS_W-1:0]  srefs [ENTRIES];
        int               srank [ENTRIES];
        bit [BYTES_W-1:0] used;
        bit [BYTES_W-1:0] budget;
        bit               unlim;
        reply_t           pending [$];
        int               mismatches;
        int               checked;
        int               evict_total;
        int               full_seen;

        function new();
            foreach (vld[i]) vld[i] = 0;
            used = 0;
            budget = 0;
            unlim = 1;
            mismatches = 0;
            checked = 0;
            evict_total = 0;
            full_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
            if (idx == sblru_pkg::REG_BUDGET)
                budget = data;
            else if (idx == sblru_pkg::REG_UNLIMITED)
                unlim = data[0];
        endfunction

        function bit [REFS_W-1:0] inc_count(bit [REFS_W-1:0] r);
            if (r != 0 && r != 16'hFFFF)
                return r + 1'b1;
            return r;
        endfunction

        function int find_slot(bit [KEY_W-1:0] k, bit [CLASS_W-1:0] c, bit only_idx);
            int best;
            best = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (vld[i] && skey[i] == k && scls[i] == c && (!only_idx || sidx[i]))
                    if (best < 0 || srank[i] < srank[best])
                        best = i;
            return best;
        endfunction

        function void promote(int s);
            for (int j = 0; j < ENTRIES; j++)
                if (vld[j] && srank[j] < srank[s])
                    srank[j]++;
            srank[s] = 0;
        endfunction

        function void drop(int s);
            for (int j = 0; j < ENTRIES; j++)
                if (j != s && vld[j] && srank[j] > srank[s])
                    srank[j]--;
            vld[s] = 0;
            used -= BYTES_W'(ssize[s]);
        endfunction

        function int ranked(int r);
            for (int j = 0; j < ENTRIES; j++)
                if (vld[j] && srank[j] == r)
                    return j;
            return -1;
        endfunction

        // Evicts unpinned entries from the old end, but only if they can
        // cover the whole excess.
        function int evict_for(bit [BYTES_W:0] excess);
            int n;
            int s;
            int ev;
            bit [BYTES_W:0] sum;
            bit ok;
            n = 0;
            ev = 0;
            sum = 0;
            ok = 0;
            foreach (vld[j]) n += int'(vld[j]);
            for (int r = n - 1; r >= 0 && !ok; r--) begin
                s = ranked(r);
                if (s >= 0 && srefs[s] == 1) begin
                    sum += (BYTES_W+1)'(ssize[s]);
                    if (sum >= excess) ok = 1;
                end
            end
            if (!ok) return 0;
            sum = 0;
            for (int r = n - 1; r >= 0; r--) begin
                s = ranked(r);
                if (s >= 0 && srefs[s] == 1) begin
                    sum += (BYTES_W+1)'(ssize[s]);
                    drop(s);
                    ev++;
                    if (sum >= excess) break;
                end
            end
            return ev;
        endfunction

        function void note_op(op_t op);
            reply_t rp;
            int s;
            bit [BYTES_W:0] need;
            rp.status = sblru_pkg::ST_MISS;
            rp.count = 0;
            rp.evicted = 0;
            rp.freed = 0;
            if (op.cmd == sblru_pkg::CMD_STORE) begin
                s = op.idx ? find_slot(op.key, op.cls, 1) : -1;
                if (s >= 0) begin
                    promote(s);
                    srefs[s] = inc_count(srefs[s]);
                    rp.status = sblru_pkg::ST_FOUND;
                    rp.count = srefs[s];
                end else begin
                    int ev;
                    ev = 0;
                    need = (BYTES_W+1)'(used) + (BYTES_W+1)'(op.size);
                    if (!unlim && need > (BYTES_W+1)'(budget))
                        ev = evict_for(need - (BYTES_W+1)'(budget));
                    rp.evicted = EVICT_W'(ev > 31 ? 31 : ev);
                    evict_total += ev;
                    s = -1;
                    for (int j = 0; j < ENTRIES; j++)
                        if (!vld[j] && s < 0) s = j;
                    if (s < 0) begin
                        rp.status = sblru_pkg::ST_FULL;
                        full_seen++;
                    end else begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (vld[j]) srank[j]++;
                        vld[s] = 1;
                        skey[s] = op.key;
                        scls[s] = op.cls;
                        sidx[s] = op.idx;
                        ssize[s] = op.size;
                        srefs[s] = inc_count(op.refs);
                        srank[s] = 0;
                        used += BYTES_W'(op.size);
                        rp.status = sblru_pkg::ST_STORED;
                        rp.count = srefs[s];
                    end
                end
            end else begin
                s = find_slot(op.key, op.cls, op.idx);
                if (s >= 0) begin
                    if (op.cmd == sblru_pkg::CMD_FIND) begin
                        promote(s);
                        srefs[s] = inc_count(srefs[s]);
                        rp.status = sblru_pkg::ST_FOUND;
                        rp.count = srefs[s];
                    end else if (op.cmd == sblru_pkg::CMD_REMOVE) begin
                        if (srefs[s] > 0) begin
                            srefs[s]--;
                            rp.freed = (srefs[s] == 0);
                        end
                        rp.count = srefs[s];
                        drop(s);
                        rp.status = sblru_pkg::ST_REMOVED;
                    end else begin
                        if (srefs[s] > 1) srefs[s]--;
                        rp.status = sblru_pkg::ST_RELEASED;
                        rp.count = srefs[s];
                    end
                end
            end
            rp.total = used;
            pending.push_back(rp);
        endfunction

        function void check_beat(reply_t got);
            reply_t exp;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing expected, status %0d",
                             got.status);
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.count !== exp.count ||
                got.evicted !== exp.evicted || got.total !== exp.total ||
                got.freed !== exp.freed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: beat %0d exp st=%0d cnt=%0d ev=%0d tot=%0d fr=%0d,",
                              " got st=%0d cnt=%0d ev=%0d tot=%0d fr=%0d"},
                             checked, exp.status, exp.count, exp.evicted, exp.total,
                             exp.freed, got.status, got.count, got.evicted, got.total,
                             got.freed);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTES_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     command;
    logic [KEY_W-1:0]     key;
    logic [CLASS_W-1:0]   key_class;
    logic                 indexed;
    logic [SIZE_W-1:0]    item_size;
    logic [REFS_W-1:0]    value_refs;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic [REFS_W-1:0]    entry_count_out;
    logic [EVICT_W-1:0]   evicted;
    logic [BYTES_W-1:0]   total_bytes;
    logic                 value_freed;

    size_budget_lru_store dut (.*);

    lru_scoreboard sb = new();
    longint unsigned cycles = 0;
    bit hold_long = 0;
    int ops_sent = 0;

    localparam longint unsigned CYCLE_LIMIT = 400000;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL size_budget_lru_store");
            $finish;
        end
    end

    // Output side: check on each accepted beat, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat('{status, entry_count_out, evicted, total_bytes, value_freed});
    end

    initial
    begin
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_long) begin
                out_ready <= 0;
                repeat (300) @(negedge clk);
                hold_long = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            out_ready <= (gap == 0);
            if (gap != 0) begin
                repeat (gap - 1) @(negedge clk);
                out_ready <= 1;
                @(negedge clk);
            end
        end
    end

    // Valid stays high across back-to-back beats and drops only for a gap.
    task automatic send_op(op_t op);
        int gap;
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1;
        command    <= op.cmd;
        key        <= op.key;
        key_class  <= op.cls;
        indexed    <= op.idx;
        item_size  <= op.size;
        value_refs <= op.refs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_op(op);
        ops_sent++;
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        stop_input();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (2 * ENTRIES + 10) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, data);
    endtask

    function automatic op_t make_op(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                    logic [CLASS_W-1:0] cl, logic ix,
                                    logic [SIZE_W-1:0] sz, logic [REFS_W-1:0] r);
        op_t op;
        op.cmd = c; op.key = k; op.cls = cl; op.idx = ix; op.size = sz; op.refs = r;
        return op;
    endfunction

    // Keys mostly come from a small pool so that hits, duplicates and
    // evictions are common; sizes are scaled to the current budget.
    function automatic op_t random_op(logic [SIZE_W-1:0] size_cap);
        op_t op;
        int sel;
        sel = $urandom_range(0, 9);
        op.cmd  = (sel < 5) ? sblru_pkg::CMD_STORE :
                  (sel < 7) ? sblru_pkg::CMD_FIND :
                  (sel < 8) ? sblru_pkg::CMD_REMOVE : sblru_pkg::CMD_RELEASE;
        op.key  = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 11);
        op.cls  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1);
        op.idx  = $urandom_range(0, 3) != 0;
        op.size = ($urandom_range(0, 29) == 0) ? $urandom() : $urandom_range(0, size_cap);
        case ($urandom_range(0, 9))
            0, 1:    op.refs = 0;
            2:       op.refs = $urandom();
            3:       op.refs = 16'hFFFF;
            4:       op.refs = 16'hFFFE;
            default: op.refs = $urandom_range(1, 3) == 1 ? 16'd0 : $urandom_range(1, 2);
        endcase
        return op;
    endfunction

    initial
    begin
        op_t op;
        logic [BYTES_W-1:0] budgets [4];
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        command = sblru_pkg::CMD_STORE;
        key = '0;
        key_class = '0;
        indexed = 0;
        item_size = '0;
        value_refs = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, merges, saturation, release floor, misses.
        send_op(make_op(sblru_pkg::CMD_FIND, 32'hFFFF_FFFF, 4'hF, 1, 0, 0));
        send_op(make_op(sblru_pkg::CMD_STORE, 32'hFFFF_FFFF, 4'hF, 1, 32'hFFFF_FFFF,
                        16'hFFFF));
        send_op(make_op(sblru_pkg::CMD_STORE, 32'hFFFF_FFFF, 4'hF, 1, 5, 3));
        send_op(make_op(sblru_pkg::CMD_FIND, 32'hFFFF_FFFF, 4'hF, 0, 0, 0));
        send_op(make_op(sblru_pkg::CMD_STORE, 0, 0, 0, 0, 0));
        send_op(make_op(sblru_pkg::CMD_STORE, 0, 0, 0, 7, 1));
        send_op(make_op(sblru_pkg::CMD_RELEASE, 0, 0, 0, 0, 0));
        send_op(make_op(sblru_pkg::CMD_FIND, 0, 0, 1, 0, 0));
        send_op(make_op(sblru_pkg::CMD_STORE, 1, 2, 1, 100, 4));
        send_op(make_op(sblru_pkg::CMD_RELEASE, 1, 2, 1, 0, 0));
        send_op(make_op(sblru_pkg::CMD_RELEASE, 1, 2, 1, 0, 0));
        send_op(make_op(sblru_pkg::CMD_RELEASE, 1, 2, 1, 0, 0));
        send_op(make_op(sblru_pkg::CMD_REMOVE, 1, 2, 1, 0, 0));
        send_op(make_op(sblru_pkg::CMD_REMOVE, 0, 0, 0, 0, 0));
        send_op(make_op(sblru_pkg::CMD_REMOVE, 0, 0, 0, 0, 0));
        for (int i = 0; i < ENTRIES + 2; i++)
            if (i < 8)
                send_op(make_op(sblru_pkg::CMD_STORE, 50 + i, 1, 1, 10, 0));
        drain();

        // Tight budget: stores over budget, with no entry that has a count of one to evict.
        write_reg(sblru_pkg::REG_BUDGET, BYTES_W'(40));
        write_reg(sblru_pkg::REG_UNLIMITED, BYTES_W'(0));
        send_op(make_op(sblru_pkg::CMD_STORE, 70, 1, 1, 20, 0));
        send_op(make_op(sblru_pkg::CMD_STORE, 71, 1, 1, 30, 0));
        send_op(make_op(sblru_pkg::CMD_STORE, 72, 1, 0, 32'hFFFF_FFFF, 1));
        drain();

        budgets[0] = 0;
        budgets[1] = 200;
        budgets[2] = 2000;
        budgets[3] = 40'hFF_FFFF_FFFF;
        for (int phase = 0; phase < 6; phase++) begin
            logic [SIZE_W-1:0] cap;
            write_reg(sblru_pkg::REG_BUDGET, budgets[phase % 4]);
            write_reg(sblru_pkg::REG_UNLIMITED, BYTES_W'(phase == 5));
            cap = (phase % 4 == 3) ? 32'hFFFF_FFFF : (phase % 4 == 2) ? 300 : 40;
            for (int n = 0; n < 135; n++) begin
                if (phase == 2 && n == 40) hold_long = 1;
                if (n == 90) begin
                    stop_input();
                    while (sb.pending.size() != 0) @(negedge clk);
                end
                op = random_op(cap);
                send_op(op);
            end
            drain();
        end

        $display("Ran %0d commands, %0d result beats checked, %0d evictions, %0d table-full.",
                 ops_sent, sb.checked, sb.evict_total, sb.full_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS size_budget_lru_store");
        else
            $display("FAIL size_budget_lru_store");
        $finish;
    end
endmodule

### sim.f
design/sblru_pkg.sv
design/size_budget_lru_store.sv
tb/tb_top.sv
